// ----- sv/nmtc_pkg.sv -----
// ----------------------------------------------------------------------------
// nmtc_pkg
// Types and constants shared by the NUMA thread migration check block.
// ----------------------------------------------------------------------------
package nmtc_pkg;

	localparam int NODES      = 4;
	localparam int MAX_SLOTS  = 1024;
	localparam int CNT_W      = 24;
	localparam int NODE_W     = $clog2(NODES);
	localparam int THR_W      = 7;
	localparam int SLOT_W     = 10;
	localparam int KEY_W      = 64;
	localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int TOT_W      = CNT_W + $clog2(NODES);
	localparam int PCT_SCALE  = 100;
	localparam int PCT_W      = $clog2(PCT_SCALE + 1);
	localparam int PEAK_PROD_W = CNT_W + PCT_W;
	localparam int TOT_PROD_W  = THR_W + 1 + TOT_W;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);

	typedef logic [NODES-1:0][CNT_W-1:0] cnt_vec_t;

	typedef struct packed {
		logic [KEY_W-1:0] thread_key;
		logic [CNT_W-1:0] cpu_count_0;
		logic [CNT_W-1:0] cpu_count_1;
		logic [CNT_W-1:0] cpu_count_2;
		logic [CNT_W-1:0] cpu_count_3;
		logic [CNT_W-1:0] mem_count_0;
		logic [CNT_W-1:0] mem_count_1;
		logic [CNT_W-1:0] mem_count_2;
		logic [CNT_W-1:0] mem_count_3;
		logic             last_in_pass;
	} in_item_t;

	typedef struct packed {
		logic              migrate;
		logic [SLOT_W-1:0] slot_index;
		logic              slot_overflow;
		logic [NODE_W-1:0] dest_node;
		logic [NODE_W-1:0] current_node;
		logic              current_node_valid;
		logic [CNT_W-1:0]  peak_mem_count;
		logic [KEY_W-1:0]  echo_key;
	} out_item_t;

	// What one node lane found
	typedef struct packed {
		logic cpu_win;
		logic mem_win;
	} lane_win_t;

	// First pipeline stage, lanes to merge
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             last;
		logic [NODES-1:0] cpu_win;
		logic [NODES-1:0] mem_win;
		cnt_vec_t         mem_cnt;
		logic [TOT_W-1:0] total;
	} stage1_t;

endpackage

// ----- sv/nmtc_lane.sv -----
// ----------------------------------------------------------------------------
// nmtc_lane
// One node lane: decides whether its node holds the first strict maximum
// of the cpu counts and of the memory counts.
// ----------------------------------------------------------------------------
module nmtc_lane (
	input  logic [nmtc_pkg::NODE_W-1:0] lane_idx,
	input  nmtc_pkg::cnt_vec_t          cpu_cnt,
	input  nmtc_pkg::cnt_vec_t          mem_cnt,
	output nmtc_pkg::lane_win_t         win
);
	import nmtc_pkg::*;

	logic [CNT_W-1:0] own_cpu;
	logic [CNT_W-1:0] own_mem;
	logic             cpu_ok;
	logic             mem_ok;

	assign own_cpu = cpu_cnt[lane_idx];
	assign own_mem = mem_cnt[lane_idx];

	// Lower nodes must be beaten strictly, higher ones only matched
	always_comb begin
		cpu_ok = (own_cpu != '0);
		mem_ok = (own_mem != '0);
		for (int j = 0; j < NODES; j++) begin
			if (NODE_W'(j) < lane_idx) begin
				cpu_ok = cpu_ok && (own_cpu > cpu_cnt[j]);
				mem_ok = mem_ok && (own_mem > mem_cnt[j]);
			end else if (NODE_W'(j) > lane_idx) begin
				cpu_ok = cpu_ok && (own_cpu >= cpu_cnt[j]);
				mem_ok = mem_ok && (own_mem >= mem_cnt[j]);
			end
		end
	end

	assign win.cpu_win = cpu_ok;
	assign win.mem_win = mem_ok;

endmodule

// ----- sv/nmtc_merge.sv -----
// ----------------------------------------------------------------------------
// nmtc_merge
// Merges the lane results: node indices, peak, cross-multiplied share test
// and slot assignment. Holds the second stage and the result register.
// ----------------------------------------------------------------------------
module nmtc_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       s2_valid,
	input  logic [nmtc_pkg::THR_W-1:0] threshold,
	input  nmtc_pkg::stage1_t          s1,
	output nmtc_pkg::out_item_t        result
);
	import nmtc_pkg::*;

	logic [NODE_W-1:0]      cpu_node;
	logic [NODE_W-1:0]      mem_node;
	logic [CNT_W-1:0]       peak;

	logic [KEY_W-1:0]       key_s2;
	logic                   last_s2;
	logic [NODE_W-1:0]      cpu_node_s2;
	logic                   cpu_valid_s2;
	logic [NODE_W-1:0]      mem_node_s2;
	logic [CNT_W-1:0]       peak_s2;
	logic                   total_nz_s2;
	logic [PEAK_PROD_W-1:0] peak_prod_s2;
	logic [TOT_PROD_W-1:0]  tot_prod_s2;

	logic                   flagged;
	logic                   slot_free;
	logic [SLOT_CNT_W-1:0]  slot_cnt_q;
	out_item_t              result_q;

	// One-hot winners to index and peak value
	always_comb begin
		cpu_node = '0;
		mem_node = '0;
		peak     = '0;
		for (int n = 0; n < NODES; n++) begin
			if (s1.cpu_win[n]) begin
				cpu_node = cpu_node | NODE_W'(n);
			end
			if (s1.mem_win[n]) begin
				mem_node = mem_node | NODE_W'(n);
				peak     = peak | s1.mem_cnt[n];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_s2       <= s1.key;
			last_s2      <= s1.last;
			cpu_node_s2  <= cpu_node;
			cpu_valid_s2 <= |s1.cpu_win;
			mem_node_s2  <= mem_node;
			peak_s2      <= peak;
			total_nz_s2  <= (s1.total != '0);
			peak_prod_s2 <= PEAK_PROD_W'(peak) * PEAK_PROD_W'(PCT_SCALE);
			tot_prod_s2  <= TOT_PROD_W'({1'b0, threshold} + (THR_W + 1)'(1))
				* TOT_PROD_W'(s1.total);
		end
	end

	// floor(peak*100/total) > thr  <=>  peak*100 >= (thr+1)*total
	assign flagged = total_nz_s2 && (peak_s2 != '0)
		&& (!cpu_valid_s2 || (cpu_node_s2 != mem_node_s2))
		&& (TOT_PROD_W'(peak_prod_s2) >= tot_prod_s2);
	assign slot_free = (slot_cnt_q < SLOT_CNT_W'(MAX_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q <= '0;
		end else if (advance && s2_valid) begin
			if (last_s2) begin
				slot_cnt_q <= '0;
			end else if (flagged && slot_free) begin
				slot_cnt_q <= slot_cnt_q + SLOT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.migrate            <= flagged;
			result_q.slot_index         <= (flagged && slot_free) ? SLOT_W'(slot_cnt_q) : '0;
			result_q.slot_overflow      <= flagged && !slot_free;
			result_q.dest_node          <= mem_node_s2;
			result_q.current_node       <= cpu_node_s2;
			result_q.current_node_valid <= cpu_valid_s2;
			result_q.peak_mem_count     <= peak_s2;
			result_q.echo_key           <= key_s2;
		end
	end

	assign result = result_q;

endmodule

// ----- sv/numa_thread_migration_check.sv -----
// ----------------------------------------------------------------------------
// numa_thread_migration_check
// Per-thread NUMA placement check: picks the busiest cpu and memory nodes
// and flags threads whose memory sits mostly on another node.
// ----------------------------------------------------------------------------
// Each request carries one thread's per-node cpu and memory sample counts.
// Four node lanes compare the counts side by side, then a merge stage
// forms the node indices, multiplies out the share test and hands out slot
// numbers via stage one, stage two and the result register. One request per
// cycle is taken whenever the result register is empty or being drained;
// a stalled result holds the whole pipeline. The threshold register must
// only be written while no request is in flight.
module numa_thread_migration_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  nmtc_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output nmtc_pkg::out_item_t        out_data,
	input  logic                       cfg_wr_en,
	input  logic [nmtc_pkg::THR_W-1:0] cfg_wr_data
);
	import nmtc_pkg::*;

	cnt_vec_t          cpu_cnt;
	cnt_vec_t          mem_cnt;
	lane_win_t         win [NODES];
	logic [NODES-1:0]  cpu_win;
	logic [NODES-1:0]  mem_win;
	logic [TOT_W-1:0]  total;
	logic              advance;
	logic [THR_W-1:0]  thr_q;
	logic              v1_q;
	logic              v2_q;
	logic              out_valid_q;
	stage1_t           st_s1;

	assign cpu_cnt = {in_data.cpu_count_3, in_data.cpu_count_2,
		in_data.cpu_count_1, in_data.cpu_count_0};
	assign mem_cnt = {in_data.mem_count_3, in_data.mem_count_2,
		in_data.mem_count_1, in_data.mem_count_0};

	for (genvar g = 0; g < NODES; g++) begin : g_lane
		nmtc_lane u_lane (
			.lane_idx (NODE_W'(g)),
			.cpu_cnt  (cpu_cnt),
			.mem_cnt  (mem_cnt),
			.win      (win[g])
		);
		assign cpu_win[g] = win[g].cpu_win;
		assign mem_win[g] = win[g].mem_win;
	end

	always_comb begin
		total = '0;
		for (int n = 0; n < NODES; n++) begin
			total = total + TOT_W'(mem_cnt[n]);
		end
	end

	// Advance every stage together unless the result is held
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (advance) begin
				v1_q        <= in_valid;
				v2_q        <= v1_q;
				out_valid_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s1.key     <= in_data.thread_key;
			st_s1.last    <= in_data.last_in_pass;
			st_s1.cpu_win <= cpu_win;
			st_s1.mem_win <= mem_win;
			st_s1.mem_cnt <= mem_cnt;
			st_s1.total   <= total;
		end
	end

	nmtc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.s2_valid  (v2_q),
		.threshold (thr_q),
		.s1        (st_s1),
		.result    (out_data)
	);

	assign out_valid = out_valid_q;

	a_lane_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> ($onehot0(st_s1.cpu_win) && $onehot0(st_s1.mem_win)))
		else $error("more than one lane claims the maximum");

	a_overflow_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.slot_overflow) |-> (out_data.migrate
			&& out_data.slot_index == '0))
		else $error("slot overflow on a thread that is not flagged");

	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.migrate) |-> (out_data.slot_index == '0
			&& !out_data.slot_overflow))
		else $error("slot given to a thread that is not flagged");

	a_no_cpu_node: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.current_node_valid) |-> (out_data.current_node == '0))
		else $error("cpu node set with all cpu counts zero");

	a_no_mem_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.peak_mem_count == '0) |-> (!out_data.migrate
			&& out_data.dest_node == '0))
		else $error("thread flagged without memory samples");

endmodule

// ----- tb/numa_thread_migration_check_tb.sv -----
// ----------------------------------------------------------------------------
// numa_thread_migration_check_tb
// Self-checking bench for the NUMA thread migration check block.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests (extremes, ties, share boundaries,
// empty counts, threshold limits) runs first. Random phases follow, with
// different thresholds and idling patterns. One phase is a single long pass
// that runs the slot counter into saturation. Each accepted request is
// predicted or given in the bench and every result is compared field by field.
// ----------------------------------------------------------------------------
module numa_thread_migration_check_tb;

	import nmtc_pkg::*;

	typedef logic [CNT_W-1:0] counts_t [NODES];

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		int        thr;
		in_item_t  item;
		bit        typed;
		out_item_t res;
	} probe_row_t;

	localparam int HEAVY_PCT  = 53;
	localparam int LIGHT_PCT  = 18;
	localparam int TAIL_CYC   = 8;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	in_item_t            in_data     = '0;
	logic                out_valid;
	logic                out_ready   = 1'b1;
	out_item_t           out_data;
	logic                cfg_wr_en   = 1'b0;
	logic [THR_W-1:0]    cfg_wr_data = '0;

	// bench copy of the block state
	logic [THR_W-1:0]    thr_pct     = THR_RESET;
	int                  slots_taken = 0;

	out_item_t           verdict_q[$];
	probe_row_t          probes[$];
	int                  faults        = 0;
	int                  send_gap_pct  = 0;
	int                  rx_stall_pct  = 0;

	numa_thread_migration_check i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

	// Busiest cpu and memory nodes, share test and slot hand-out
	function automatic out_item_t migration_verdict(in_item_t it);
		counts_t           cpu;
		counts_t           mem;
		logic [CNT_W-1:0]  cbest;
		logic [CNT_W-1:0]  mbest;
		int                cn;
		int                mn;
		bit                cv;
		bit                mv;
		longint unsigned   total;
		bit                flag;
		out_item_t         r;
		cpu = '{it.cpu_count_0, it.cpu_count_1, it.cpu_count_2, it.cpu_count_3};
		mem = '{it.mem_count_0, it.mem_count_1, it.mem_count_2, it.mem_count_3};
		cbest = '0;
		mbest = '0;
		cn = 0;
		mn = 0;
		cv = 1'b0;
		mv = 1'b0;
		total = 0;
		for (int n = 0; n < NODES; n++) begin
			if (cpu[n] > cbest) begin
				cbest = cpu[n];
				cn = n;
				cv = 1'b1;
			end
			if (mem[n] > mbest) begin
				mbest = mem[n];
				mn = n;
				mv = 1'b1;
			end
			total += mem[n];
		end
		flag = mv && total != 0 && (!cv || cn != mn) &&
			(longint'(mbest) * PCT_SCALE >= (longint'(thr_pct) + 1) * total);
		r = '0;
		r.migrate = flag;
		if (flag) begin
			if (slots_taken < MAX_SLOTS) begin
				r.slot_index = SLOT_W'(slots_taken);
				slots_taken++;
			end else begin
				r.slot_overflow = 1'b1;
			end
		end
		r.dest_node          = NODE_W'(mn);
		r.current_node       = NODE_W'(cn);
		r.current_node_valid = cv;
		r.peak_mem_count     = mbest;
		r.echo_key           = it.thread_key;
		if (it.last_in_pass)
			slots_taken = 0;
		return r;
	endfunction

	function automatic in_item_t load(logic [KEY_W-1:0] key, counts_t cpu, counts_t mem,
			bit last);
		in_item_t it;
		it.thread_key   = key;
		it.cpu_count_0  = cpu[0];
		it.cpu_count_1  = cpu[1];
		it.cpu_count_2  = cpu[2];
		it.cpu_count_3  = cpu[3];
		it.mem_count_0  = mem[0];
		it.mem_count_1  = mem[1];
		it.mem_count_2  = mem[2];
		it.mem_count_3  = mem[3];
		it.last_in_pass = last;
		return it;
	endfunction

	function automatic logic [CNT_W-1:0] any_count();
		case ($urandom_range(9))
			0, 1: return '0;
			2: return '1;
			3: return CNT_W'($urandom_range(15));
			default: return CNT_W'($urandom);
		endcase
	endfunction

	// Unshaped counts, with a tie forced now and then
	function automatic in_item_t noise_item(bit last);
		counts_t c;
		counts_t m;
		for (int n = 0; n < NODES; n++) begin
			c[n] = any_count();
			m[n] = any_count();
		end
		if ($urandom_range(3) == 0)
			c[$urandom_range(NODES-1)] = c[$urandom_range(NODES-1)];
		if ($urandom_range(3) == 0)
			m[$urandom_range(NODES-1)] = m[$urandom_range(NODES-1)];
		return load({$urandom, $urandom}, c, m, last);
	endfunction

	// Memory peaks away from the busiest cpu node: a likely migration
	function automatic in_item_t flagged_shape(bit last);
		counts_t          c;
		counts_t          m;
		int               mn;
		int               cn;
		logic [CNT_W-1:0] peak;
		logic [CNT_W-1:0] cpeak;
		mn = $urandom_range(NODES-1);
		cn = (mn + $urandom_range(1, NODES-1)) % NODES;
		peak = $urandom_range(1) ? (CNT_W'($urandom) | CNT_W'(1))
			: CNT_W'($urandom_range(1, 200));
		cpeak = $urandom_range(1) ? (CNT_W'($urandom) | CNT_W'(1))
			: CNT_W'($urandom_range(1, 50));
		for (int n = 0; n < NODES; n++) begin
			if (n == mn)
				m[n] = peak;
			else if ($urandom_range(3) == 0)
				m[n] = CNT_W'($urandom_range(0, peak - 1));
			else
				m[n] = peak >> $urandom_range(1, CNT_W);
			c[n] = (n == cn) ? cpeak : CNT_W'($urandom_range(0, cpeak - 1));
		end
		if ($urandom_range(9) == 0)
			c = '{default: '0};
		return load({$urandom, $urandom}, c, m, last);
	endfunction

	task automatic compare_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (want !== got) begin
			faults++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(negedge clk)
		out_ready = ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				faults++;
				$display("%0t: result with nothing expected, expected none, got key %h",
					$time, out_data.echo_key);
			end else begin
				want = verdict_q.pop_front();
				compare_field("migrate", want.migrate, out_data.migrate);
				compare_field("slot_index", want.slot_index, out_data.slot_index);
				compare_field("slot_overflow", want.slot_overflow, out_data.slot_overflow);
				compare_field("dest_node", want.dest_node, out_data.dest_node);
				compare_field("current_node", want.current_node, out_data.current_node);
				compare_field("current_node_valid", want.current_node_valid,
					out_data.current_node_valid);
				compare_field("peak_mem_count", want.peak_mem_count, out_data.peak_mem_count);
				compare_field("echo_key", want.echo_key, out_data.echo_key);
			end
		end
	end

	// Offer one request, hold it until taken, then log its expected result
	task automatic drive_item(in_item_t it, bit typed, out_item_t typed_res);
		out_item_t want;
		@(negedge clk);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = it;
		do
			@(posedge clk);
		while (!in_ready);
		want = migration_verdict(it);
		verdict_q.push_back(typed ? typed_res : want);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_threshold(int v);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = THR_W'(v);
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		thr_pct     = THR_W'(v);
	endtask

	task automatic run_phase(idle_mode_t mode, int thr, int n_items, bit long_pass);
		in_item_t it;
		bit       last;
		settle();
		case (mode)
			IDLE_NONE: begin
				send_gap_pct = 0;
				rx_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_gap_pct = HEAVY_PCT;
				rx_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_gap_pct = 0;
				rx_stall_pct = HEAVY_PCT;
			end
			IDLE_BOTH: begin
				send_gap_pct = LIGHT_PCT;
				rx_stall_pct = LIGHT_PCT;
			end
		endcase
		write_threshold(thr);
		for (int k = 0; k < n_items; k++) begin
			last = long_pass ? (k == n_items - 1) : ($urandom_range(7) == 0);
			if ($urandom_range(99) < (long_pass ? 97 : 70))
				it = flagged_shape(last);
			else
				it = noise_item(last);
			drive_item(it, 1'b0, '0);
		end
	endtask

	initial begin
		probes.push_back('{thr: 50, typed: 1'b1,
			item: load('0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0),
			res: '{migrate: 1'b0, slot_index: '0, slot_overflow: 1'b0, dest_node: '0,
				current_node: '0, current_node_valid: 1'b0, peak_mem_count: '0,
				echo_key: '0}});
		probes.push_back('{thr: 50, typed: 1'b1,
			item: load('1, '{default: '1}, '{default: '1}, 1'b0),
			res: '{migrate: 1'b0, slot_index: '0, slot_overflow: 1'b0, dest_node: '0,
				current_node: '0, current_node_valid: 1'b1, peak_mem_count: '1,
				echo_key: '1}});
		probes.push_back('{thr: 50, typed: 1'b1,
			item: load(64'h1, '{0, 5, 0, 0}, '{9, 0, 0, 0}, 1'b0),
			res: '{migrate: 1'b1, slot_index: '0, slot_overflow: 1'b0, dest_node: 2'd0,
				current_node: 2'd1, current_node_valid: 1'b1, peak_mem_count: 24'd9,
				echo_key: 64'h1}});
		// no cpu samples at all still counts as a different node
		probes.push_back('{thr: 50, typed: 1'b1,
			item: load(64'h0000_0123_0000_0456, '{0, 0, 0, 0}, '{0, 0, 0, 24'hFFFFFF}, 1'b1),
			res: '{migrate: 1'b1, slot_index: 10'd1, slot_overflow: 1'b0, dest_node: 2'd3,
				current_node: 2'd0, current_node_valid: 1'b0, peak_mem_count: 24'hFFFFFF,
				echo_key: 64'h0000_0123_0000_0456}});
		// share just over and exactly at the threshold
		probes.push_back('{thr: 50, typed: 1'b0, res: '0,
			item: load(64'h10, '{0, 0, 0, 7}, '{51, 49, 0, 0}, 1'b0)});
		probes.push_back('{thr: 50, typed: 1'b0, res: '0,
			item: load(64'h11, '{0, 0, 0, 7}, '{50, 25, 25, 0}, 1'b0)});
		// ties go to the lower node
		probes.push_back('{thr: 50, typed: 1'b0, res: '0,
			item: load(64'h12, '{3, 8, 8, 1}, '{2, 6, 6, 6}, 1'b0)});
		probes.push_back('{thr: 50, typed: 1'b0, res: '0,
			item: load(64'h13, '{0, 0, 4, 4}, '{0, 0, 0, 10}, 1'b0)});
		probes.push_back('{thr: 50, typed: 1'b0, res: '0,
			item: load(64'h14, '{9, 9, 9, 9}, '{0, 0, 0, 0}, 1'b0)});
		probes.push_back('{thr: 50, typed: 1'b0, res: '0,
			item: load(64'h15, '{0, 0, 1, 0}, '{24'hFFFFFF, 24'hFFFFFF, 0, 0}, 1'b0)});
		probes.push_back('{thr: 0, typed: 1'b0, res: '0,
			item: load(64'h20, '{0, 1, 0, 0}, '{1, 1, 1, 1}, 1'b0)});
		probes.push_back('{thr: 0, typed: 1'b0, res: '0,
			item: load(64'h21, '{0, 1, 0, 0}, '{0, 0, 0, 0}, 1'b0)});
		// a full share never exceeds a threshold of a hundred or more
		probes.push_back('{thr: 100, typed: 1'b0, res: '0,
			item: load(64'h30, '{1, 0, 0, 0}, '{0, 0, 5, 0}, 1'b0)});
		probes.push_back('{thr: 99, typed: 1'b0, res: '0,
			item: load(64'h31, '{1, 0, 0, 0}, '{0, 0, 5, 0}, 1'b0)});
		probes.push_back('{thr: 127, typed: 1'b0, res: '0,
			item: load(64'h32, '{1, 0, 0, 0}, '{0, 0, 5, 0}, 1'b0)});
		probes.push_back('{thr: 127, typed: 1'b0, res: '0,
			item: load('1, '{0, 0, 0, 24'hFFFFFF}, '{24'hFFFFFF, 0, 0, 0}, 1'b1)});
		probes.push_back('{thr: 50, typed: 1'b0, res: '0,
			item: load(64'hA5A5_5A5A_A5A5_5A5A, '{24'h555555, 24'hAAAAAA, 24'h555555, 0},
				'{0, 24'h555555, 24'hAAAAAA, 24'h000001}, 1'b0)});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (probes[i]) begin
			if (probes[i].thr != thr_pct) begin
				settle();
				write_threshold(probes[i].thr);
			end
			drive_item(probes[i].item, probes[i].typed, probes[i].res);
		end

		run_phase(IDLE_NONE, 50, 40, 1'b0);
		// one long pass to run the slot counter past its limit
		run_phase(IDLE_SEND, 0, 1100, 1'b1);
		run_phase(IDLE_RECV, 100, 50, 1'b0);
		run_phase(IDLE_BOTH, 127, 40, 1'b0);
		run_phase(IDLE_BOTH, $urandom_range(1, 99), 40, 1'b0);
		run_phase(IDLE_NONE, $urandom_range(0, 127), 30, 1'b0);

		settle();
		repeat (TAIL_CYC) @(negedge clk);
		if (faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/nmtc_pkg.sv
sv/nmtc_lane.sv
sv/nmtc_merge.sv
sv/numa_thread_migration_check.sv
tb/numa_thread_migration_check_tb.sv
